// ===== rtl/arts_pkg.sv =====
// Shared types, codes and constants for the address range flag tag store.
// Used by the top module, the datapath and the controller; depends on nothing else.
package arts_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 13;
    localparam int FLAG_W  = 4;
    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 3;

    // Default configuration of the store.
    localparam int NUM_REGIONS_DEF    = 4;
    localparam int REGION_ENTRIES_DEF = 4096;

    // Largest region length the length register can hold.
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLR   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_HOLE  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLRALL = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  length;
        logic [FLAG_W-1:0] flag_mask;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic              test_result;
        logic [FLAG_W-1:0] flag_value;
        logic              hole_found;
        logic [ADDR_W-1:0] hole_start;
        logic [LEN_W-1:0]  hole_length;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic lookup;
        logic clr_step;
        logic rd_cur;
        logic rd_pos;
        logic mod_wr;
        logic hole_step;
        logic res_load;
        logic res_zero;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;
        logic              cur_lt_end;
        logic              next_lt_end;
        logic              hole_stop;
        logic              clr_last;
    } status_t;

endpackage

// ===== rtl/address_range_flag_tag_store_unit.sv =====
// Address range flag tag store: 4-bit flags per address in up to four regions.
// Point queries (test, read) go through lookup, dispatch, a tag read and its evaluation
// before result_valid rises; the next item is taken only once the result has left.
// Set and clear add a read and a write per nibble in range, the next-hole search a read
// and an evaluation per nibble walked, all set by the single tag RAM port pair. Clear all
// clears a byte per cycle, 8192 by default; after reset this sweep runs before any item.
module address_range_flag_tag_store_unit #(
    parameter int NUM_REGIONS    = arts_pkg::NUM_REGIONS_DEF,
    parameter int REGION_ENTRIES = arts_pkg::REGION_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  arts_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output arts_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [arts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arts_pkg::ADDR_W-1:0]    cfg_data
);

    arts_pkg::cmd_t    cmd;
    arts_pkg::status_t status;
    logic              ready;

    arts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd),
        .ready        (ready),
        .result_valid (result_valid)
    );

    arts_dp #(
        .NUM_REGIONS    (NUM_REGIONS),
        .REGION_ENTRIES (REGION_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign item_stall = !ready;

    // The block never takes an item while a result is waiting.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && !item_stall))
        else $error("item taken while result pending");

    // A transfer in is followed by a stalled input until the result is out.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input not stalled after transfer");

    // A found hole always lies in a region.
    a_hole: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hole_found) |-> result.hit)
        else $error("hole found outside any region");

    // A positive test needs a nonzero stored nibble.
    a_test: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.test_result) |-> (result.flag_value != '0))
        else $error("test hit on empty nibble");

endmodule

// ===== rtl/arts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the tag store datapath.
module arts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/arts_dp.sv =====
// Datapath of the tag store: configuration, region lookup, walk cursor,
// tag RAM and result register. Depends on arts_pkg and arts_ram.
module arts_dp #(
    parameter int NUM_REGIONS    = arts_pkg::NUM_REGIONS_DEF,
    parameter int REGION_ENTRIES = arts_pkg::REGION_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [arts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arts_pkg::ADDR_W-1:0]    cfg_data,
    input  arts_pkg::item_t                item,
    input  arts_pkg::cmd_t                 cmd,
    output arts_pkg::status_t              status,
    output arts_pkg::result_t              result
);

    localparam int LW  = arts_pkg::LEN_W;
    localparam int BPR = (REGION_ENTRIES + 1) / 2;
    localparam int DEPTH = NUM_REGIONS * BPR;
    localparam int AW  = $clog2(DEPTH);
    localparam int RW  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int RE_CLIP = (REGION_ENTRIES > arts_pkg::LEN_MAX) ?
                             arts_pkg::LEN_MAX : REGION_ENTRIES;

    logic [arts_pkg::ADDR_W-1:0] base_reg [NUM_REGIONS];
    logic [LW-1:0]               len_reg  [NUM_REGIONS];
    arts_pkg::item_t             item_reg;
    logic                        hit_reg;
    logic [RW-1:0]               rsel_reg;
    logic [LW-1:0]               pos_reg;
    logic [LW-1:0]               rl_reg;
    logic [LW-1:0]               end_reg;
    logic [LW-1:0]               cur_reg, cur_next;
    logic [LW-1:0]               start_reg;
    logic                        found_reg;
    logic                        phase_reg;
    logic [AW-1:0]               clr_reg;
    arts_pkg::result_t           result_reg;

    logic [LW-1:0]               effl [NUM_REGIONS];
    logic                        lk_hit;
    logic [RW-1:0]               lk_rsel;
    logic [LW-1:0]               lk_pos;
    logic [LW:0]                 lk_sum;
    logic [LW-1:0]               lk_end;
    logic [arts_pkg::ADDR_W-1:0] off [NUM_REGIONS];

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr, cur_byte, pos_byte;
    logic [arts_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic [arts_pkg::FLAG_W-1:0] nib, new_nib;
    logic                        nib_set;
    logic                        rd_odd_reg;

    // Configuration registers; writes to regions not built are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                base_reg[r] <= '0;
                len_reg[r]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                if (cfg_index[arts_pkg::CFG_IDX_W-1:1] == (arts_pkg::CFG_IDX_W-1)'(r))
                begin
                    if (cfg_index[0])
                    begin
                        len_reg[r] <= cfg_data[LW-1:0];
                    end
                    else
                    begin
                        base_reg[r] <= cfg_data;
                    end
                end
            end
        end
    end

    // Region lookup: first region whose window holds the address wins.
    always_comb
    begin
        lk_hit  = 1'b0;
        lk_rsel = '0;
        lk_pos  = '0;
        for (int r = NUM_REGIONS - 1; r >= 0; r--)
        begin
            effl[r] = (len_reg[r] > LW'(RE_CLIP)) ? LW'(RE_CLIP) : len_reg[r];
            off[r]  = item_reg.addr - base_reg[r];
            if (off[r] < {{(arts_pkg::ADDR_W-LW){1'b0}}, effl[r]})
            begin
                lk_hit  = 1'b1;
                lk_rsel = RW'(r);
                lk_pos  = off[r][LW-1:0];
            end
        end
        lk_sum = {1'b0, lk_pos} + {1'b0, item_reg.length};
        lk_end = (lk_sum > {1'b0, effl[lk_rsel]}) ? effl[lk_rsel] : lk_sum[LW-1:0];
    end

    // Byte addresses: two nibbles per byte, even offset in the low half.
    assign cur_byte = AW'(rsel_reg) * AW'(BPR) + AW'(cur_reg[LW-1:1]);
    assign pos_byte = AW'(rsel_reg) * AW'(BPR) + AW'(pos_reg[LW-1:1]);

    assign nib     = rd_odd_reg ? ram_rdata[7:4] : ram_rdata[3:0];
    assign nib_set = (nib & item_reg.flag_mask) != '0;
    assign new_nib = (item_reg.func == arts_pkg::FUNC_SET) ? (nib | item_reg.flag_mask) : '0;

    // RAM port selection: clearing sweep or nibble update.
    always_comb
    begin
        ram_we    = cmd.clr_step | cmd.mod_wr;
        ram_waddr = cmd.clr_step ? clr_reg : cur_byte;
        ram_wdata = '0;
        if (!cmd.clr_step)
        begin
            ram_wdata = cur_reg[0] ? {new_nib, ram_rdata[3:0]} : {ram_rdata[7:4], new_nib};
        end
        ram_raddr = cmd.rd_pos ? pos_byte : cur_byte;
    end

    arts_ram #(
        .WIDTH (arts_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cursor advance for range walks and the hole search.
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.mod_wr)
        begin
            cur_next = cur_reg + 1'b1;
        end
        else if (cmd.hole_step && !(phase_reg && nib_set))
        begin
            cur_next = cur_reg + 1'b1;
        end
    end

    // Sweep counter, reset to the first byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= (clr_reg == AW'(DEPTH - 1)) ? '0 : clr_reg + 1'b1;
        end
    end

    // Item, lookup, walk and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.lookup)
        begin
            hit_reg   <= lk_hit;
            rsel_reg  <= lk_rsel;
            pos_reg   <= lk_pos;
            rl_reg    <= effl[lk_rsel];
            end_reg   <= lk_end;
            cur_reg   <= lk_pos;
            found_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
        if (cmd.hole_step && !phase_reg && !nib_set)
        begin
            start_reg <= cur_reg;
            found_reg <= 1'b1;
            phase_reg <= 1'b1;
        end
        if (cmd.rd_cur || cmd.rd_pos)
        begin
            rd_odd_reg <= cmd.rd_pos ? pos_reg[0] : cur_reg[0];
        end
        if (cmd.res_zero)
        begin
            result_reg <= '0;
        end
        else if (cmd.res_load)
        begin
            result_reg.hit         <= 1'b1;
            result_reg.test_result <= nib_set;
            result_reg.flag_value  <= nib;
            result_reg.hole_found  <= found_reg;
            result_reg.hole_start  <= found_reg ?
                base_reg[rsel_reg] + {{(arts_pkg::ADDR_W-LW){1'b0}}, start_reg} : '0;
            result_reg.hole_length <= found_reg ? cur_reg - start_reg : '0;
        end
    end

    // Status back to the controller.
    assign status.func        = item_reg.func;
    assign status.hit         = hit_reg;
    assign status.cur_lt_end  = cur_reg < end_reg;
    assign status.next_lt_end = ({1'b0, cur_reg} + 1'b1) < {1'b0, end_reg};
    assign status.hole_stop   = (phase_reg && nib_set) ||
                                (({1'b0, cur_reg} + 1'b1) == {1'b0, rl_reg});
    assign status.clr_last    = clr_reg == AW'(DEPTH - 1);

    assign result = result_reg;

endmodule

// ===== rtl/arts_ctrl.sv =====
// Controller of the tag store: sequences clearing sweeps, range walks,
// hole searches and the result handshake. Depends on arts_pkg.
module arts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              result_stall,
    input  arts_pkg::status_t status,
    output arts_pkg::cmd_t    cmd,
    output logic              ready,
    output logic              result_valid
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_DISP, ST_S_RD, ST_S_MOD,
        ST_H_RD, ST_H_EV, ST_F_RD, ST_F_EV, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;
    logic   ready_reg, valid_reg;
    logic   accept;

    assign accept = item_valid && ready_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    cmd.res_zero = reply_reg;
                    state_next   = reply_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.func == arts_pkg::FUNC_CLRALL)
                begin
                    reply_next = 1'b1;
                    state_next = ST_CLEAR;
                end
                else if (status.func > arts_pkg::FUNC_CLRALL)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (!status.hit)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    case (status.func) inside
                        arts_pkg::FUNC_SET, arts_pkg::FUNC_CLR:
                            state_next = status.cur_lt_end ? ST_S_RD : ST_F_RD;
                        arts_pkg::FUNC_HOLE:
                            state_next = ST_H_RD;
                        default:
                            state_next = ST_F_RD;
                    endcase
                end
            end
            ST_S_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = ST_S_MOD;
            end
            ST_S_MOD:
            begin
                cmd.mod_wr = 1'b1;
                state_next = status.next_lt_end ? ST_S_RD : ST_F_RD;
            end
            ST_H_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = ST_H_EV;
            end
            ST_H_EV:
            begin
                cmd.hole_step = 1'b1;
                state_next    = status.hole_stop ? ST_F_RD : ST_H_RD;
            end
            ST_F_RD:
            begin
                cmd.rd_pos = 1'b1;
                state_next = ST_F_EV;
            end
            ST_F_EV:
            begin
                cmd.res_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    reply_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            reply_reg <= 1'b0;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            ready_reg <= (state_next == ST_IDLE);
            valid_reg <= (state_next == ST_OUT);
        end
    end

    assign ready        = ready_reg;
    assign result_valid = valid_reg;

endmodule
